/* sv/wip_pkg.sv */
// package for the weighted id pool draw block
// operation and status codes, default sizes; no dependencies
`timescale 1ns / 1ps

package wip_pkg;

  localparam int unsigned DEF_CAPACITY = 256;
  localparam int unsigned DEF_ID_BITS  = 8;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned QTY_W  = 9;
  localparam int unsigned RND_W  = 31;
  localparam int unsigned SIZE_W = 9;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_DRAW   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

endpackage

/* sv/weighted_id_pool_draw.sv */
// top level of the weighted id pool draw block: pool memory and its sequencer
// depends on wip_pkg
`timescale 1ns / 1ps

// An ordered pool of ids kept in one single-port-write, one-read memory of
// CAPACITY entries. A command is taken when start is high and busy low; its
// single result appears on drawn_id, status and pool_size for one cycle with
// done high, and must be taken then. Clear, and add or remove with zero
// quantity, answer in the cycle after the command. Add writes one copy per
// cycle. Remove compacts the pool through the memory read port, one entry
// per cycle. Draw reduces random_value by the pool size one bit per cycle
// and then reads the memory; a draw from an empty pool answers at once.
module weighted_id_pool_draw #(
  parameter int unsigned CAPACITY = wip_pkg::DEF_CAPACITY,
  parameter int unsigned ID_BITS  = wip_pkg::DEF_ID_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind,
  input  logic [wip_pkg::ID_W-1:0]    machine_id,
  input  logic [wip_pkg::QTY_W-1:0]   quantity,
  input  logic [wip_pkg::RND_W-1:0]   random_value,
  output logic                        done,
  output logic [wip_pkg::ID_W-1:0]    drawn_id,
  output logic [1:0]                  status,
  output logic [wip_pkg::SIZE_W-1:0]  pool_size
);

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned QW    = (CNT_W > wip_pkg::QTY_W) ? CNT_W : wip_pkg::QTY_W;
  localparam int unsigned BW    = $clog2(wip_pkg::RND_W);

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_REM, S_MOD, S_RD, S_OUT
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          count;
  logic [ID_BITS-1:0]        op_id;
  logic [QW-1:0]             left;
  logic [CNT_W-1:0]          src;
  logic [CNT_W-1:0]          dst;
  logic                      pv;
  logic [wip_pkg::RND_W-1:0] rnd;
  logic [CNT_W-1:0]          rem;
  logic [BW-1:0]             bitcnt;
  logic [1:0]                stat;

  logic [ID_BITS-1:0] mem [CAPACITY];
  logic [ID_BITS-1:0] rd_data;
  logic [AW-1:0]      ra;
  logic [AW-1:0]      wa;
  logic [ID_BITS-1:0] wd;
  logic               we;

  logic [ID_BITS-1:0] id_in;
  logic [QW-1:0]      room;
  logic [QW-1:0]      qty_x;
  logic               skip;
  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     cnt_x;

  assign busy  = (state != S_IDLE);
  assign id_in = ID_BITS'(machine_id);
  assign room  = QW'(CAPACITY) - QW'(count);
  assign qty_x = QW'(quantity);
  assign skip  = pv && (left != '0) && (rd_data == op_id);
  assign trial = {rem, rnd[wip_pkg::RND_W-1]};
  assign cnt_x = {1'b0, count};

  // memory port control
  always_comb begin
    we = 1'b0;
    wa = count[AW-1:0];
    wd = op_id;
    ra = (state == S_REM) ? src[AW-1:0] : rem[AW-1:0];
    case (state)
      S_ADD: begin
        we = 1'b1;
      end
      S_REM: begin
        we = pv && !skip;
        wa = dst[AW-1:0];
        wd = rd_data;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      done      <= 1'b0;
      drawn_id  <= '0;
      status    <= wip_pkg::ST_OK;
      pool_size <= '0;
      pv        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_id    <= id_in;
            drawn_id <= '0;
            case (kind)
              wip_pkg::KIND_ADD: begin
                stat <= (qty_x > room) ? wip_pkg::ST_OVERFLOW : wip_pkg::ST_OK;
                left <= (qty_x > room) ? room : qty_x;
                if (qty_x == '0 || room == '0) begin
                  done      <= 1'b1;
                  status    <= (qty_x > room) ? wip_pkg::ST_OVERFLOW : wip_pkg::ST_OK;
                  pool_size <= wip_pkg::SIZE_W'(count);
                end else begin
                  state <= S_ADD;
                end
              end
              wip_pkg::KIND_REMOVE: begin
                left <= qty_x;
                src  <= '0;
                dst  <= '0;
                pv   <= 1'b0;
                if (quantity == '0) begin
                  done      <= 1'b1;
                  status    <= wip_pkg::ST_OK;
                  pool_size <= wip_pkg::SIZE_W'(count);
                end else begin
                  state <= S_REM;
                end
              end
              wip_pkg::KIND_DRAW: begin
                rnd    <= random_value;
                rem    <= '0;
                bitcnt <= '0;
                if (count == '0) begin
                  done      <= 1'b1;
                  status    <= wip_pkg::ST_EMPTY;
                  pool_size <= '0;
                end else begin
                  state <= S_MOD;
                end
              end
              default: begin
                count     <= '0;
                done      <= 1'b1;
                status    <= wip_pkg::ST_OK;
                pool_size <= '0;
              end
            endcase
          end
        end
        S_ADD: begin
          count <= count + 1'b1;
          left  <= left - 1'b1;
          if (left == QW'(1)) begin
            done      <= 1'b1;
            status    <= stat;
            pool_size <= wip_pkg::SIZE_W'(count + 1'b1);
            state     <= S_IDLE;
          end
        end
        S_REM: begin
          if (pv) begin
            if (skip) begin
              left <= left - 1'b1;
            end else begin
              dst <= dst + 1'b1;
            end
          end
          if (src < count) begin
            src <= src + 1'b1;
            pv  <= 1'b1;
          end else begin
            pv <= 1'b0;
            if (!pv) begin
              count     <= dst;
              done      <= 1'b1;
              status    <= wip_pkg::ST_OK;
              pool_size <= wip_pkg::SIZE_W'(dst);
              state     <= S_IDLE;
            end
          end
        end
        S_MOD: begin
          rnd    <= rnd << 1;
          rem    <= (trial >= cnt_x) ? CNT_W'(trial - cnt_x) : CNT_W'(trial);
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == BW'(wip_pkg::RND_W - 1)) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          done      <= 1'b1;
          drawn_id  <= wip_pkg::ID_W'(rd_data);
          status    <= wip_pkg::ST_OK;
          pool_size <= wip_pkg::SIZE_W'(count);
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("pool count beyond capacity");

  a_add_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD |-> left != '0 && count < CNT_W'(CAPACITY))
    else $error("add step with nothing left or no room");

  a_rem_order: assert property (@(posedge clk) disable iff (rst)
    state == S_REM |-> dst <= src)
    else $error("compaction write ahead of read");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && status == wip_pkg::ST_EMPTY |-> drawn_id == '0 && pool_size == '0)
    else $error("empty draw result not clean");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == wip_pkg::KIND_CLEAR |=> done && pool_size == '0)
    else $error("clear did not answer with empty pool");

endmodule
